@@ hw/rtl/ema_pkg.sv @@
// Shared types, widths and the microcode store for the exponential moving average.
// Used by the sequencer, divider, datapath and top level; depends on nothing else.
package ema_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int WIN_W      = 9;
	localparam int SUM_W      = 40;
	localparam int WEIGHT_W   = 17;
	localparam int DIV_W      = 40;
	localparam int DIVISOR_W  = WIN_W + 1;
	localparam int CNT_W      = 6;
	localparam int PROD_W     = SAMPLE_W + 1 + WEIGHT_W + 1;
	localparam int UPC_W      = 4;
	localparam int WEIGHT_NUM_W = 18;
	localparam int FRAC_BITS  = 16;

	localparam logic [WIN_W-1:0] WIN_RESET = 9'd10;
	localparam logic [DIV_W-1:0] WEIGHT_DIVIDEND =
		{18'h20000, {(DIV_W - WEIGHT_NUM_W){1'b0}}};
	localparam logic [CNT_W-1:0] WEIGHT_STEPS = 6'(WEIGHT_NUM_W);
	localparam logic [CNT_W-1:0] MEAN_STEPS   = 6'(DIV_W);

	typedef enum logic [2:0] {
		DP_NOP,
		DP_FETCH,
		DP_WSTORE,
		DP_SEED,
		DP_MEAN,
		DP_PAD,
		DP_MUL,
		DP_EMA
	} dp_op_t;

	typedef enum logic [1:0] {
		DV_NONE,
		DV_LOAD_WEIGHT,
		DV_LOAD_MEAN,
		DV_STEP
	} div_cmd_t;

	typedef enum logic [2:0] {
		CD_NEXT,
		CD_ALWAYS,
		CD_NO_INPUT,
		CD_CLEAN,
		CD_DIV_MORE,
		CD_EMA,
		CD_SEED_OPEN
	} cond_t;

	typedef struct packed {
		dp_op_t            op;
		div_cmd_t          dv;
		logic              emit;
		cond_t             cond;
		logic [UPC_W-1:0]  target;
	} ctl_word_t;

	typedef struct packed {
		logic in_valid;
		logic dirty;
		logic ema_case;
		logic seed_open;
		logic div_more;
		logic out_busy;
	} seq_status_t;

	localparam logic [UPC_W-1:0] UA_FETCH    = 4'd0;
	localparam logic [UPC_W-1:0] UA_WDIV     = 4'd3;
	localparam logic [UPC_W-1:0] UA_CLASSIFY = 4'd5;
	localparam logic [UPC_W-1:0] UA_MDIV     = 4'd8;
	localparam logic [UPC_W-1:0] UA_PAD      = 4'd10;
	localparam logic [UPC_W-1:0] UA_MUL      = 4'd11;

	function automatic ctl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
		ctl_word_t cw;
		cw = '{op: DP_NOP, dv: DV_NONE, emit: 1'b0, cond: CD_ALWAYS, target: UA_FETCH};
		case (addr)
			4'd0: cw = '{DP_FETCH,  DV_NONE,        1'b0, CD_NO_INPUT,  UA_FETCH};
			4'd1: cw = '{DP_NOP,    DV_NONE,        1'b0, CD_CLEAN,     UA_CLASSIFY};
			4'd2: cw = '{DP_NOP,    DV_LOAD_WEIGHT, 1'b0, CD_NEXT,      UA_FETCH};
			4'd3: cw = '{DP_NOP,    DV_STEP,        1'b0, CD_DIV_MORE,  UA_WDIV};
			4'd4: cw = '{DP_WSTORE, DV_NONE,        1'b0, CD_NEXT,      UA_FETCH};
			4'd5: cw = '{DP_NOP,    DV_NONE,        1'b0, CD_EMA,       UA_MUL};
			4'd6: cw = '{DP_SEED,   DV_NONE,        1'b0, CD_SEED_OPEN, UA_PAD};
			4'd7: cw = '{DP_NOP,    DV_LOAD_MEAN,   1'b0, CD_NEXT,      UA_FETCH};
			4'd8: cw = '{DP_NOP,    DV_STEP,        1'b0, CD_DIV_MORE,  UA_MDIV};
			4'd9: cw = '{DP_MEAN,   DV_NONE,        1'b1, CD_ALWAYS,    UA_FETCH};
			4'd10: cw = '{DP_PAD,   DV_NONE,        1'b1, CD_ALWAYS,    UA_FETCH};
			4'd11: cw = '{DP_MUL,   DV_NONE,        1'b0, CD_NEXT,      UA_FETCH};
			4'd12: cw = '{DP_EMA,   DV_NONE,        1'b1, CD_ALWAYS,    UA_FETCH};
			default: cw = '{DP_NOP, DV_NONE,        1'b0, CD_ALWAYS,    UA_FETCH};
		endcase
		return cw;
	endfunction

endpackage

@@ hw/rtl/ema_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on ema_pkg for the control word, status and microcode store.
module ema_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  ema_pkg::seq_status_t status,
	output ema_pkg::ctl_word_t  cw,
	output logic                step_en
);
	import ema_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic             take;

	assign cw      = ucode_rom(upc_q);
	assign step_en = !(cw.emit && status.out_busy);

	always_comb begin
		unique case (cw.cond)
			CD_NEXT:      take = 1'b0;
			CD_ALWAYS:    take = 1'b1;
			CD_NO_INPUT:  take = !status.in_valid;
			CD_CLEAN:     take = !status.dirty;
			CD_DIV_MORE:  take = status.div_more;
			CD_EMA:       take = status.ema_case;
			CD_SEED_OPEN: take = status.seed_open;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_FETCH;
		end else if (step_en) begin
			upc_q <= take ? cw.target : upc_q + 1'b1;
		end
	end

endmodule

@@ hw/rtl/ema_div.sv @@
// Serial restoring divider, one quotient bit per cycle, for the weight and the seed mean.
// Depends on ema_pkg for widths and divider commands.
module ema_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ema_pkg::div_cmd_t              cmd,
	input  logic [ema_pkg::WIN_W-1:0]      win,
	input  logic signed [ema_pkg::SUM_W-1:0] sum,
	output logic [ema_pkg::DIV_W-1:0]      quotient,
	output logic                           more
);
	import ema_pkg::*;

	logic [DIV_W-1:0]     div_q;
	logic [WIN_W-1:0]     rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] trial;
	logic                 qbit;

	assign trial    = {rem_q, div_q[DIV_W-1]};
	assign qbit     = (trial >= divisor_q);
	assign quotient = div_q;
	assign more     = (cnt_q != 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd)
				DV_LOAD_WEIGHT: cnt_q <= WEIGHT_STEPS;
				DV_LOAD_MEAN:   cnt_q <= MEAN_STEPS;
				DV_STEP:        cnt_q <= cnt_q - 1'b1;
				default:        cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			DV_LOAD_WEIGHT: begin
				div_q     <= WEIGHT_DIVIDEND;
				rem_q     <= '0;
				divisor_q <= {1'b0, win} + 1'b1;
			end
			DV_LOAD_MEAN: begin
				div_q     <= sum[SUM_W-1] ? DIV_W'(-sum) : DIV_W'(sum);
				rem_q     <= '0;
				divisor_q <= {1'b0, win};
			end
			DV_STEP: begin
				div_q <= {div_q[DIV_W-2:0], qbit};
				rem_q <= qbit ? WIN_W'(trial - divisor_q) : trial[WIN_W-1:0];
			end
			default: begin
				div_q <= div_q;
			end
		endcase
	end

endmodule

@@ hw/rtl/ema_dp.sv @@
// Datapath: window and weight registers, seed sum, running average, multiplier and
// output register. Depends on ema_pkg; driven by the sequencer's control word.
module ema_dp #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ema_pkg::ctl_word_t               cw,
	input  logic                             step_en,
	input  logic                             cfg_wr_en,
	input  logic [ema_pkg::WIN_W-1:0]        cfg_wr_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ema_pkg::SAMPLE_W-1:0]     s_axis_tdata,
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ema_pkg::SAMPLE_W-1:0]     m_axis_tdata,
	output logic                             m_axis_tuser,
	input  logic [ema_pkg::DIV_W-1:0]        quotient,
	output logic [ema_pkg::WIN_W-1:0]        win,
	output logic signed [ema_pkg::SUM_W-1:0] sum,
	output logic                             dirty,
	output logic                             ema_case,
	output logic                             seed_open,
	output logic                             out_busy
);
	import ema_pkg::*;

	localparam int WIN_CAP_I = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
	localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WIN_CAP_I);

	logic [WIN_W-1:0]           win_len_q;
	logic                       dirty_q;
	logic [WEIGHT_W-1:0]        weight_q;
	logic [WIN_W-1:0]           seen_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        out_data_q;
	logic                       out_ready_q;

	logic                       accept;
	logic                       emit;
	logic [WIN_W:0]             seen_inc;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0]        mean_mag;
	logic [SAMPLE_W-1:0]        mean;
	logic signed [PROD_W-FRAC_BITS-1:0] step_amt;
	logic [SAMPLE_W-1:0]        ema_res;

	always_comb begin
		if (win_len_q == '0) begin
			win = WIN_W'(1);
		end else if (win_len_q > WIN_CAP) begin
			win = WIN_CAP;
		end else begin
			win = win_len_q;
		end
	end

	assign s_axis_tready = (cw.op == DP_FETCH);
	assign accept        = s_axis_tready && s_axis_tvalid;
	assign emit          = cw.emit && step_en;
	assign seen_inc      = {1'b0, seen_q} + 1'b1;
	assign seed_open     = (seen_inc < {1'b0, win});
	assign ema_case      = (seen_q >= win);
	assign dirty         = dirty_q;
	assign sum           = sum_q;
	assign out_busy      = out_valid_q && !m_axis_tready;

	assign diff     = (SAMPLE_W + 1)'(x_q) - (SAMPLE_W + 1)'(prev_q);
	assign prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, weight_q}));
	assign mean_mag = quotient[SAMPLE_W-1:0];
	assign mean     = sum_q[SUM_W-1] ? SAMPLE_W'(-mean_mag) : mean_mag;
	assign step_amt = prod_q[PROD_W-1:FRAC_BITS];
	assign ema_res  = SAMPLE_W'(PROD_W'(prev_q) + PROD_W'(step_amt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WIN_RESET;
			dirty_q     <= 1'b1;
			weight_q    <= '0;
			seen_q      <= '0;
			sum_q       <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				win_len_q <= cfg_wr_data;
				dirty_q   <= 1'b1;
			end else if (cw.op == DP_WSTORE) begin
				dirty_q  <= 1'b0;
				weight_q <= quotient[WEIGHT_W-1:0];
			end
			if (accept && s_axis_tuser) begin
				seen_q <= '0;
				sum_q  <= '0;
			end
			if (cw.op == DP_SEED) begin
				seen_q <= seen_inc[WIN_W-1:0];
				sum_q  <= sum_q + SUM_W'(x_q);
			end
			if (emit && cw.op == DP_MEAN) begin
				prev_q <= mean;
			end
			if (emit && cw.op == DP_EMA) begin
				prev_q <= ema_res;
				seen_q <= win;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= s_axis_tdata;
		end
		if (cw.op == DP_MUL) begin
			prod_q <= prod;
		end
		if (emit) begin
			case (cw.op)
				DP_MEAN: begin
					out_data_q  <= mean;
					out_ready_q <= 1'b1;
				end
				DP_EMA: begin
					out_data_q  <= ema_res;
					out_ready_q <= 1'b1;
				end
				default: begin
					out_data_q  <= '0;
					out_ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ready_q;

endmodule

@@ hw/rtl/exponential_moving_average.sv @@
// Exponential moving average of signed Q16.16 samples, seeded with the truncated mean of
// the first window of each series. A series starts at reset or at a transfer with tuser
// set. One result transfer leaves for every input transfer: zero with tuser low while the
// seed window fills, then the seed mean, then prev + floor((x - prev) * weight / 65536)
// with weight = floor(131072 / (window + 1)). A microcoded sequencer steps a serial
// divider and a single multiplier. The sample that completes the seed waits for a
// divider pass over the seed sum, and after reset or a window write the next sample first
// spends a divider pass computing the weight. The output register lets a new sample enter
// while the last result still waits to be taken.
module exponential_moving_average #(
	parameter int MAX_WINDOW = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,    // window_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // sample_value
	input  logic        s_axis_tuser,   // series_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // average_value
	output logic        m_axis_tuser    // value_ready
);
	import ema_pkg::*;

	ctl_word_t               cw;
	logic                    step_en;
	seq_status_t             status;
	logic [DIV_W-1:0]        quotient;
	logic                    div_more;
	logic [WIN_W-1:0]        win;
	logic signed [SUM_W-1:0] sum;
	logic                    dirty;
	logic                    ema_case;
	logic                    seed_open;
	logic                    out_busy;

	assign status = '{
		in_valid:  s_axis_tvalid,
		dirty:     dirty,
		ema_case:  ema_case,
		seed_open: seed_open,
		div_more:  div_more,
		out_busy:  out_busy
	};

	ema_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.status  (status),
		.cw      (cw),
		.step_en (step_en)
	);

	ema_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cw.dv),
		.win      (win),
		.sum      (sum),
		.quotient (quotient),
		.more     (div_more)
	);

	ema_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cw            (cw),
		.step_en       (step_en),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.quotient      (quotient),
		.win           (win),
		.sum           (sum),
		.dirty         (dirty),
		.ema_case      (ema_case),
		.seed_open     (seed_open),
		.out_busy      (out_busy)
	);

endmodule

@@ tb/sv/tb_exponential_moving_average.sv @@
// Self-checking testbench for exponential_moving_average: a directed table followed by
// random series under random source and sink stalls, checked against an in-bench predictor.
// Depends on ema_pkg and the exponential_moving_average RTL only.
module tb_exponential_moving_average;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WINDOW = 256;
	localparam int RANDOM_SAMPLES = 1500;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 80;

	typedef struct packed {
		logic [ema_pkg::SAMPLE_W-1:0] avg;
		logic                         rdy;
	} avg_t;

	typedef struct packed {
		logic                         is_cfg;
		logic [ema_pkg::WIN_W-1:0]    win;
		logic                         start;
		logic [ema_pkg::SAMPLE_W-1:0] x;
		logic                         typed;
		logic [ema_pkg::SAMPLE_W-1:0] exp_avg;
		logic                         exp_rdy;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [8:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	exponential_moving_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	logic [8:0]  win_setting;
	int          seed_count;
	int          seed_terms;
	longint      seed_total;
	longint      last_average;
	logic [16:0] ema_weight;

	avg_t pending_averages[$];
	bit   use_typed = 1'b0;
	avg_t typed_result = '0;
	bit   hold_out = 1'b0;
	int   errors = 0;
	int   samples_sent = 0;
	int   idle_cycles = 0;

	plan_row_t directed_plan [29] = '{
		'{1'b0, 9'd0,   1'b0, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b1, 32'h80000000, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h00000000, 1'b1, 32'h0, 1'b0},
		'{1'b1, 9'd2,   1'b0, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{1'b1, 9'd10,  1'b0, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b1, 32'hFFFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h80000000, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h00010000, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'hFFFF0000, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h12345678, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'hDEADBEEF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h00000001, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h80000000, 1'b0, 32'h0, 1'b0},
		'{1'b1, 9'd1,   1'b0, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b1, 32'h80000000, 1'b1, 32'h80000000, 1'b1},
		'{1'b0, 9'd0,   1'b0, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b1},
		'{1'b1, 9'd0,   1'b0, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h00012345, 1'b1, 32'h00012345, 1'b1},
		'{1'b1, 9'd511, 1'b0, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h80000000, 1'b1, 32'h0, 1'b0},
		'{1'b1, 9'd2,   1'b0, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b0, 32'h40000000, 1'b0, 32'h0, 1'b0},
		'{1'b1, 9'd256, 1'b0, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 9'd0,   1'b1, 32'h00000001, 1'b1, 32'h0, 1'b0}
	};

	function automatic int active_window();
		int w;
		w = int'(win_setting);
		if (w == 0) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w;
	endfunction

	function automatic void set_window(input logic [8:0] v);
		win_setting = v;
		ema_weight = 17'(131072 / (active_window() + 1));
	endfunction

	function automatic avg_t predict_average(input logic start, input logic [31:0] raw);
		int     win;
		longint x;
		longint r;
		avg_t   res;
		win = active_window();
		x = longint'($signed(raw));
		if (start) begin
			seed_count = 0;
			seed_total = 0;
			seed_terms = 0;
		end
		if (seed_count + 1 < win) begin
			seed_total += x;
			seed_count++;
			seed_terms++;
			r = 0;
			res.rdy = 1'b0;
		end else if (seed_count + 1 == win) begin
			seed_total += x;
			seed_terms++;
			seed_count = win;
			r = seed_total / longint'(win);
			last_average = r;
			res.rdy = 1'b1;
		end else begin
			// Arithmetic shift gives the floor of the weighted step.
			r = last_average + (((x - last_average) * longint'(ema_weight)) >>> 16);
			last_average = r;
			seed_count = win;
			res.rdy = 1'b1;
		end
		res.avg = r[31:0];
		return res;
	endfunction

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3: return 32'($urandom_range(0, 131071)) - 32'd65536;
			default: return 32'($urandom());
		endcase
	endfunction

	task automatic send_sample(input logic start, input logic [31:0] x, input bit brisk,
			input bit typed, input avg_t typed_val);
		int unsigned gap;
		gap = brisk ? 0 : $urandom_range(0, 19);
		repeat (gap) @(negedge clk);
		s_axis_tdata = x;
		s_axis_tuser = start;
		use_typed = typed;
		typed_result = typed_val;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_window(input logic [8:0] v);
		wait (pending_averages.size() == 0);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		set_window(v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin : accept_side
		avg_t fresh;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			fresh = predict_average(s_axis_tuser, s_axis_tdata);
			if (use_typed) fresh = typed_result;
			pending_averages.push_back(fresh);
		end
	end

	always @(posedge clk) begin : result_side
		avg_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_averages.size() == 0) begin
				$display("%0t: unexpected transfer, average %h ready %b", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = pending_averages.pop_front();
				if (m_axis_tdata !== want.avg) begin
					$display("%0t: average_value expected %h actual %h", $time,
						want.avg, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.rdy) begin
					$display("%0t: value_ready expected %b actual %b", $time,
						want.rdy, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : sink
		int unsigned gap;
		bit recv_brisk;
		recv_brisk = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0) recv_brisk = !recv_brisk;
			if (hold_out) begin
				hold_out = 1'b0;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = recv_brisk ? 0 : $urandom_range(0, 19);
				if (gap > 0) begin
					m_axis_tready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		avg_t        typed_val;
		logic [8:0]  w_val;
		int          win;
		int          phase;
		int unsigned phase_len;
		int unsigned series_left;
		bit          send_brisk;
		logic        st;
		set_window(ema_pkg::WIN_RESET);
		seed_count = 0;
		seed_terms = 0;
		seed_total = 0;
		last_average = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg) begin
				write_window(directed_plan[i].win);
			end else begin
				typed_val.avg = directed_plan[i].exp_avg;
				typed_val.rdy = directed_plan[i].exp_rdy;
				send_sample(directed_plan[i].start, directed_plan[i].x, 1'b0,
					directed_plan[i].typed, typed_val);
			end
		end

		typed_val = '0;
		send_brisk = 1'b0;
		phase = 0;
		samples_sent = 0;
		while (samples_sent < RANDOM_SAMPLES) begin
			phase++;
			case ($urandom_range(0, 19))
				0: w_val = 9'd0;
				1: w_val = 9'd1;
				2: w_val = 9'd2;
				3: w_val = 9'd256;
				4: w_val = 9'd511;
				5: w_val = 9'($urandom_range(257, 511));
				6, 7: w_val = 9'($urandom_range(17, 255));
				default: w_val = 9'($urandom_range(1, 16));
			endcase
			if (phase == 2) w_val = 9'd4;
			write_window(w_val);
			win = active_window();
			phase_len = (win > 40) ? win + $urandom_range(10, 40) : $urandom_range(30, 80);
			// Sometimes the series runs on across the window change.
			series_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : 0;
			if (phase == 2) hold_out = 1'b1;
			for (int n = 0; n < phase_len; n++) begin
				if ($urandom_range(0, 63) == 0) send_brisk = !send_brisk;
				if (series_left == 0) begin
					st = 1'b1;
					if (win > 1 && $urandom_range(0, 5) == 0)
						series_left = $urandom_range(1, win - 1);
					else
						series_left = win + $urandom_range(0, 40);
				end else begin
					st = ($urandom_range(0, 59) == 0);
				end
				// Keep the seed sum within its 40-bit range across window changes.
				if (!st && seed_count < win && seed_terms >= MAX_WINDOW) st = 1'b1;
				series_left--;
				if ($urandom_range(0, 199) == 0) begin
					wait (pending_averages.size() == 0);
					@(negedge clk);
				end
				send_sample(st, pick_sample(), send_brisk || (phase == 2 && n < 12),
					1'b0, typed_val);
			end
		end

		wait (pending_averages.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
